// File: hw/rtl/apl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_pkg
// Shared types and constants of the audio peak level meter.
// ----------------------------------------------------------------------------
package apl_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int CHANNELS_MAX = 8;

	localparam int SAMPLE_W  = 32;
	localparam int CHANNEL_W = 3;
	localparam int LEVEL_W   = 8;
	localparam int FORMAT_W  = 3;

	// APB register map
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_IDX_FORMAT = 1'b0;

	// Level scaling
	localparam int FLOAT_GAIN    = 127;
	localparam int FLOAT_SHIFT   = 24;
	localparam int S32_SHIFT     = 26;
	localparam int S16_SHIFT     = 10;
	localparam int S8_SHIFT      = 1;
	localparam int LEVEL_MAX     = 255;

	typedef enum logic [FORMAT_W-1:0] {
		FMT_FLOAT32 = 3'd0,
		FMT_S32     = 3'd1,
		FMT_S16     = 3'd2,
		FMT_U8      = 3'd3,
		FMT_S8      = 3'd4
	} fmt_t;

	localparam fmt_t FORMAT_RESET = FMT_S16;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} sample_item_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic [LEVEL_W-1:0]   level;
		logic                 last_of_run;
	} level_result_t;

endpackage

// File: hw/rtl/audio_peak_level_meter_top.sv
`timescale 1ns / 1ps
// Path: a last word goes from the input register to the snapshot register, then to the result register.
// Throughput: one word per cycle; a last word queues CHANNELS results that
// leave one per cycle from the snapshot register while result_ready holds, and the next last word waits
// in the input register, holding off item_ready, until that snapshot has emptied.
// Reset: arst_n clears the trackers, channel counter and valid flags;
// the sample format returns to signed 16-bit.
// ----------------------------------------------------------------------------
// audio_peak_level_meter_top
// Per-channel peak level meter over interleaved audio sample buffers.
// ----------------------------------------------------------------------------
module audio_peak_level_meter_top
	import apl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  sample_item_t       item,
	output logic               result_valid,
	input  logic               result_ready,
	output level_result_t      result
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	fmt_t                       fmt;
	logic                       snap_load;
	logic                       snap_free;
	logic signed [SAMPLE_W-1:0] snap_min [CHANNELS];
	logic signed [SAMPLE_W-1:0] snap_max [CHANNELS];

	apl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fmt     (fmt)
	);

	apl_track #(
		.CHANNELS (CHANNELS),
		.CW       (CW)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.fmt        (fmt),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.snap_free  (snap_free),
		.snap_load  (snap_load),
		.snap_min   (snap_min),
		.snap_max   (snap_max)
	);

	apl_drain #(
		.CHANNELS (CHANNELS),
		.CW       (CW)
	) u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.fmt          (fmt),
		.snap_load    (snap_load),
		.snap_min     (snap_min),
		.snap_max     (snap_max),
		.snap_free    (snap_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: hw/rtl/apl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_cfg
// APB register file holding the sample format.
// ----------------------------------------------------------------------------
module apl_cfg
	import apl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output fmt_t               fmt
);

	logic [FORMAT_W-1:0] fmt_q;
	logic                hit;

	assign hit    = (paddr[PADDR_W-1] == REG_IDX_FORMAT);
	assign pready = 1'b1;
	assign fmt    = fmt_t'(fmt_q);
	assign prdata = hit ? {{(PDATA_W-FORMAT_W){1'b0}}, fmt_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FORMAT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			fmt_q <= pwdata[FORMAT_W-1:0];
		end
	end

endmodule

// File: hw/rtl/apl_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_track
// Input stage: sample conversion and per-channel min/max tracking.
// ----------------------------------------------------------------------------
module apl_track
	import apl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fmt_t                       fmt,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  sample_item_t               item,
	input  logic                       snap_free,
	output logic                       snap_load,
	output logic signed [SAMPLE_W-1:0] snap_min [CHANNELS],
	output logic signed [SAMPLE_W-1:0] snap_max [CHANNELS]
);

	logic                       v_s1;
	logic [SAMPLE_W-1:0]        sample_s1;
	logic                       last_s1;
	logic [CW-1:0]              pos_q;
	logic signed [SAMPLE_W-1:0] min_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] max_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] conv;
	logic                       adv;

	function automatic logic signed [SAMPLE_W-1:0] float_to_q24(logic [SAMPLE_W-1:0] raw);
		logic [7:0]  expo;
		logic [30:0] mag;
		logic [4:0]  shamt;
		expo  = raw[30:23];
		shamt = 5'(8'd133 - expo);
		mag   = '0;
		if (expo == 8'd255) begin
			mag = (raw[22:0] != '0) ? '0 : '1;
		end else if (expo == 8'd0) begin
			mag = '0;
		end else if (expo >= 8'd134) begin
			mag = '1;
		end else if (expo >= 8'd103) begin
			mag = {1'b1, raw[22:0], 7'b0} >> shamt;
		end
		return raw[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] convert(logic [SAMPLE_W-1:0] raw, fmt_t f);
		logic signed [SAMPLE_W-1:0] r;
		case (f)
			FMT_FLOAT32: r = float_to_q24(raw);
			FMT_S16:     r = SAMPLE_W'($signed(raw[15:0]));
			FMT_U8:      r = SAMPLE_W'($signed({~raw[7], raw[6:0]}));
			FMT_S8:      r = SAMPLE_W'($signed(raw[7:0]));
			default:     r = $signed(raw);
		endcase
		return r;
	endfunction

	assign conv       = convert(sample_s1, fmt);
	assign adv        = v_s1 && (!last_s1 || snap_free);
	assign item_ready = !v_s1 || adv;
	assign snap_load  = adv && last_s1;

	// Snapshot sees the trackers with this word already folded in
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			snap_min[c] = min_q[c];
			snap_max[c] = max_q[c];
		end
		if (min_q[pos_q] > conv) begin
			snap_min[pos_q] = conv;
		end else if (max_q[pos_q] < conv) begin
			snap_max[pos_q] = conv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			sample_s1 <= item.sample;
			last_s1   <= item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				min_q[c] <= '0;
				max_q[c] <= '0;
			end
		end else if (adv) begin
			if (last_s1) begin
				// End of buffer: clear trackers and restart at channel zero
				pos_q <= '0;
				for (int c = 0; c < CHANNELS; c++) begin
					min_q[c] <= '0;
					max_q[c] <= '0;
				end
			end else begin
				pos_q <= (pos_q == CW'(CHANNELS - 1)) ? '0 : pos_q + 1'b1;
				min_q <= snap_min;
				max_q <= snap_max;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |-> snap_free)
		else $error("snapshot loaded while still draining");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= CW'(CHANNELS - 1))
		else $error("channel position out of range");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		snap_load |=> (pos_q == '0))
		else $error("channel position not restarted after last word");

endmodule

// File: hw/rtl/apl_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_drain
// Peak snapshot, level scaling and result register; one channel per cycle while result_ready holds.
// ----------------------------------------------------------------------------
module apl_drain
	import apl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fmt_t                       fmt,
	input  logic                       snap_load,
	input  logic signed [SAMPLE_W-1:0] snap_min [CHANNELS],
	input  logic signed [SAMPLE_W-1:0] snap_max [CHANNELS],
	output logic                       snap_free,
	output logic                       result_valid,
	input  logic                       result_ready,
	output level_result_t              result
);

	logic signed [SAMPLE_W-1:0] min_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] max_q [CHANNELS];
	logic                       busy_q;
	logic [CW-1:0]              idx_q;
	logic                       out_valid_q;
	level_result_t              out_q;
	logic                       out_load;
	logic                       idx_last;

	function automatic logic [LEVEL_W-1:0] peak_level(logic signed [SAMPLE_W-1:0] mn,
			logic signed [SAMPLE_W-1:0] mx, fmt_t f);
		logic signed [33:0] negmin;
		logic signed [33:0] lim;
		logic signed [33:0] pk;
		logic signed [40:0] scaled;
		logic [LEVEL_W-1:0] lvl;
		negmin = -34'(mn);
		case (f)
			FMT_S16:         lim = 34'sd32767;
			FMT_U8, FMT_S8:  lim = 34'sd127;
			default:         lim = 34'sd2147483647;
		endcase
		pk = 34'(mx);
		if (negmin > 34'(mx) + 34'sd1) begin
			pk = (negmin > lim) ? lim : negmin;
		end
		case (f)
			FMT_FLOAT32:    scaled = (41'(pk) * 41'(FLOAT_GAIN)) >>> FLOAT_SHIFT;
			FMT_S32:        scaled = 41'(pk) >>> S32_SHIFT;
			FMT_S16:        scaled = 41'(pk) >>> S16_SHIFT;
			FMT_U8, FMT_S8: scaled = 41'(pk) >>> S8_SHIFT;
			default:        scaled = '0;
		endcase
		if (scaled < 0) begin
			lvl = '0;
		end else if (scaled > 41'(LEVEL_MAX)) begin
			lvl = LEVEL_W'(LEVEL_MAX);
		end else begin
			lvl = scaled[LEVEL_W-1:0];
		end
		return lvl;
	endfunction

	assign idx_last     = (idx_q == CW'(CHANNELS - 1));
	assign out_load     = busy_q && (!out_valid_q || result_ready);
	assign snap_free    = !busy_q || (out_load && idx_last);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk) begin
		if (snap_load) begin
			min_q <= snap_min;
			max_q <= snap_max;
		end
		if (out_load) begin
			out_q.channel     <= CHANNEL_W'(idx_q);
			out_q.level       <= peak_level(min_q[idx_q], max_q[idx_q], fmt);
			out_q.last_of_run <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (snap_load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_load) begin
				// Advance to the next channel, drop busy after the final one
				busy_q <= !idx_last;
				idx_q  <= idx_last ? '0 : idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (idx_q == '0))
		else $error("drain index not parked while idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(CHANNELS - 1))
		else $error("drain index out of range");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && idx_last && !snap_load) |=> !busy_q)
		else $error("drain still busy after final channel");

endmodule
